// ----- rtl/u2gb_pkg.sv -----
// Shared types and constants for the code point to GB2312 lookup block.
// No dependencies; used by every module under rtl.
package u2gb_pkg;

  localparam int TABLE_DEPTH_DEF = 8192;
  localparam int COUNT_W         = 14;
  localparam int ADDR_FIELD_W    = 13;
  localparam int KEY_W           = 16;
  localparam int POS_W           = 13;
  localparam int REM_W           = 7;
  localparam int QUOT_W          = 7;

  // position / 94 == (position >> 1) / 47 == ((position >> 1) * 2789) >> 17
  // for every 13-bit position
  localparam int RECIP_MUL    = 2789;
  localparam int RECIP_SHIFT  = 17;
  localparam int RECIP_PROD_W = 24;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 14'd8192;
  localparam logic [7:0]         ROW_LEN     = 8'd94;
  localparam logic [7:0]         ROW_BASE    = 8'hB0;
  localparam logic [7:0]         COL_BASE    = 8'hA1;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_LOAD   = 1'b1;

  typedef struct packed {
    logic                    operation;
    logic [ADDR_FIELD_W-1:0] entry_address;
    logic [KEY_W-1:0]        code_point;
    logic [POS_W-1:0]        gb_position;
  } in_item_t;

  typedef struct packed {
    logic       not_found;
    logic [7:0] gb_high;
    logic [7:0] gb_low;
  } out_item_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [POS_W-1:0] pos;
  } entry_t;

  typedef struct packed {
    logic             start;
    logic [POS_W-1:0] dividend;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [POS_W-1:0] quot;
    logic [REM_W-1:0] rem;
  } div_rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROBE,
    S_CHECK,
    S_DIV,
    S_OUT
  } state_e;

endpackage

// ----- rtl/u2gb_table.sv -----
// Sorted key/position table: one write port, one read port, registered read.
// Depends on u2gb_pkg for the entry type.
module u2gb_table #(
  parameter int DEPTH = u2gb_pkg::TABLE_DEPTH_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  u2gb_pkg::entry_t wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output u2gb_pkg::entry_t rd_data_o
);

  u2gb_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

// ----- rtl/u2gb_divmod.sv -----
// Reciprocal divider by the GB2312 row length: position / 94 and % 94 in two steps.
// Depends on u2gb_pkg for widths, constants and request/response structs.
module u2gb_divmod (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  u2gb_pkg::div_req_t req_i,
  output u2gb_pkg::div_rsp_t rsp_o
);

  logic [u2gb_pkg::POS_W-1:0]        pos_q, pos_d;
  logic [u2gb_pkg::QUOT_W-1:0]       quot_q, quot_d;
  logic [u2gb_pkg::REM_W-1:0]        rem_q, rem_d;
  logic                              stage1_q, stage2_q;
  logic [u2gb_pkg::RECIP_PROD_W-1:0] prod;
  logic [u2gb_pkg::POS_W-1:0]        back;

  // quotient first, remainder from the registered quotient in the next cycle
  assign prod = u2gb_pkg::RECIP_PROD_W'(req_i.dividend[u2gb_pkg::POS_W-1:1]) *
                u2gb_pkg::RECIP_PROD_W'(u2gb_pkg::RECIP_MUL);
  assign back = u2gb_pkg::POS_W'(quot_q) * u2gb_pkg::POS_W'(u2gb_pkg::ROW_LEN);

  always_comb begin
    pos_d  = pos_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    if (req_i.start) begin
      pos_d  = req_i.dividend;
      quot_d = prod[u2gb_pkg::RECIP_SHIFT +: u2gb_pkg::QUOT_W];
    end
    if (stage1_q) begin
      rem_d = u2gb_pkg::REM_W'(pos_q - back);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage1_q <= 1'b0;
      stage2_q <= 1'b0;
    end else begin
      stage1_q <= req_i.start;
      stage2_q <= stage1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    quot_q <= quot_d;
    rem_q  <= rem_d;
  end

  assign rsp_o.done = stage2_q;
  assign rsp_o.quot = u2gb_pkg::POS_W'(quot_q);
  assign rsp_o.rem  = rem_q;

endmodule

// ----- rtl/unicode_to_gb2312_lookup.sv -----
// Top level: binary-search sequencer over the sorted table, divider, output register.
// Depends on u2gb_pkg, u2gb_table and u2gb_divmod.
//
//   channel | dir | handshake              | payload
//   in      | in  | in_valid_i/in_ready_o   | in_data_i  (in_item_t)
//   out     | out | out_valid_o/out_ready_i | out_data_o (out_item_t)
//   cfg     | in  | cfg_valid_i/cfg_ready_o | cfg_data_i (entries_in_use)
//
// A load writes its entry into the table when accepted. A lookup probes the
// table (table read, then compare), at most 14 probes for 8192 entries, then on
// a hit passes through the reciprocal divider, and goes into the output register.
// Reset sets entries_in_use to 8192; table contents are undefined until loaded.
// in_ready_o is low while a lookup runs; a result waits in the output register
// and the next request is taken meanwhile. A finished lookup stalls in its last
// step while the output register is still full.
module unicode_to_gb2312_lookup #(
  parameter int TABLE_DEPTH = u2gb_pkg::TABLE_DEPTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  u2gb_pkg::in_item_t                 in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output u2gb_pkg::out_item_t                out_data_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [u2gb_pkg::COUNT_W-1:0]       cfg_data_i
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int IW = AW + 1;

  u2gb_pkg::state_e state_q, state_d;

  logic [u2gb_pkg::COUNT_W-1:0] entries_q;
  logic [IW-1:0]                lo_q, lo_d, hi_q, hi_d, mid_q, mid_d, n_clamp;
  logic [u2gb_pkg::KEY_W-1:0]   key_q, key_d;
  logic                         hit_q, hit_d;
  logic                         out_valid_q, out_valid_d;
  u2gb_pkg::out_item_t          out_q, out_d;

  logic             accept, wr_en, rd_en, addr_ok;
  u2gb_pkg::entry_t wr_data, rd_data;
  u2gb_pkg::div_req_t div_req;
  u2gb_pkg::div_rsp_t div_rsp;

  assign accept      = in_valid_i && in_ready_o;
  assign in_ready_o  = (state_q == u2gb_pkg::S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign n_clamp = (32'(entries_q) > 32'(TABLE_DEPTH)) ? IW'(TABLE_DEPTH)
                                                       : IW'(entries_q);

  // loads beyond the table are dropped
  assign addr_ok = (32'(in_data_i.entry_address) < 32'(TABLE_DEPTH));
  assign wr_en   = accept && (in_data_i.operation == u2gb_pkg::OP_LOAD) && addr_ok;
  assign wr_data = '{key: in_data_i.code_point, pos: in_data_i.gb_position};

  u2gb_table #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (AW'(in_data_i.entry_address)),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (AW'(mid_d)),
    .rd_data_o (rd_data)
  );

  u2gb_divmod u_divmod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_d          = state_q;
    lo_d             = lo_q;
    hi_d             = hi_q;
    mid_d            = lo_q + ((hi_q - lo_q) >> 1);
    key_d            = key_q;
    hit_d            = hit_q;
    out_valid_d      = out_valid_q;
    out_d            = out_q;
    rd_en            = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = rd_data.pos;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      u2gb_pkg::S_IDLE: begin
        if (accept && (in_data_i.operation == u2gb_pkg::OP_LOOKUP)) begin
          key_d = in_data_i.code_point;
          lo_d  = '0;
          hi_d  = n_clamp - IW'(1);
          hit_d = 1'b0;
          state_d = (n_clamp == '0) ? u2gb_pkg::S_OUT : u2gb_pkg::S_PROBE;
        end
      end
      u2gb_pkg::S_PROBE: begin
        rd_en   = 1'b1;
        state_d = u2gb_pkg::S_CHECK;
      end
      u2gb_pkg::S_CHECK: begin
        if (rd_data.key == key_q) begin
          hit_d         = 1'b1;
          div_req.start = 1'b1;
          state_d       = u2gb_pkg::S_DIV;
        end else if (rd_data.key < key_q) begin
          lo_d    = mid_q + IW'(1);
          state_d = (mid_q + IW'(1) > hi_q) ? u2gb_pkg::S_OUT : u2gb_pkg::S_PROBE;
        end else begin
          hi_d = mid_q - IW'(1);
          if (mid_q == '0 || lo_q > mid_q - IW'(1)) begin
            state_d = u2gb_pkg::S_OUT;
          end else begin
            state_d = u2gb_pkg::S_PROBE;
          end
        end
      end
      u2gb_pkg::S_DIV: begin
        if (div_rsp.done) begin
          state_d = u2gb_pkg::S_OUT;
        end
      end
      u2gb_pkg::S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          if (hit_q) begin
            out_d.not_found = 1'b0;
            out_d.gb_high   = u2gb_pkg::ROW_BASE + div_rsp.quot[7:0];
            out_d.gb_low    = u2gb_pkg::COL_BASE + 8'(div_rsp.rem);
          end else begin
            out_d.not_found = 1'b1;
            out_d.gb_high   = '0;
            out_d.gb_low    = '0;
          end
          state_d = u2gb_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = u2gb_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= u2gb_pkg::S_IDLE;
      entries_q   <= u2gb_pkg::COUNT_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        entries_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    key_q <= key_d;
    hit_q <= hit_d;
    out_q <= out_d;
    if (state_q == u2gb_pkg::S_PROBE) begin
      mid_q <= mid_d;
    end
  end

  // a probe never reads past the searched range
  a_probe_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == u2gb_pkg::S_PROBE |-> lo_q <= hi_q && hi_q < n_clamp)
    else $error("probe outside searched range");

  // a miss carries zero bytes
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.not_found |-> out_data_o.gb_high == '0 &&
    out_data_o.gb_low == '0)
    else $error("miss result with nonzero bytes");

  // on a hit the column byte comes from a remainder below the row length
  a_hit_column: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.not_found |->
    out_data_o.gb_low >= u2gb_pkg::COL_BASE &&
    out_data_o.gb_low <= u2gb_pkg::COL_BASE + 8'd93)
    else $error("hit column byte out of range");

  // the divider only finishes while the sequencer waits for it
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == u2gb_pkg::S_DIV)
    else $error("divider finished outside the divide step");

endmodule
